// File: src/flc_pkg.sv
// ----------------------------------------------------------------------------
// flc_pkg: shared definitions for the block cache
// Sizes, configuration register indexes and the structs that pass between
// the lookup, the slot store and the top level.
// ----------------------------------------------------------------------------
package flc_pkg;

  localparam int ENTRIES    = 8;
  localparam int BLOCK_BITS = 16;

  // Fixed widths of the ports.
  localparam int REF_W      = 16;
  localparam int SLOT_OUT_W = 3;
  localparam int EVB_W      = 16;
  localparam int CNT_W      = 32;
  localparam int SIU_W      = 4;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 1;

  // Internal widths that follow from the entry count.
  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W  = SLOT_W;
  localparam int FILL_W = $clog2(ENTRIES + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = CFG_IDX_W'(1);

  typedef logic [BLOCK_BITS-1:0] blk_t;
  typedef logic [AGE_W-1:0]      age_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [FILL_W-1:0]     fill_t;

  typedef blk_t [ENTRIES-1:0] blk_arr_t;
  typedef age_t [ENTRIES-1:0] age_arr_t;

  // Result of the parallel search over the filled slots.
  typedef struct packed {
    logic  hit;
    slot_t hit_slot;
    slot_t old_slot;
  } look_t;

  // Update command from the top level to the slot store.
  typedef struct packed {
    logic  en;
    logic  hit;
    logic  lru;
    logic  grow;
    slot_t slot;
    blk_t  blk;
  } upd_t;

endpackage

// File: src/flc_lookup.sv
// ----------------------------------------------------------------------------
// flc_lookup: parallel tag compare and victim pick
// Compares a block number against every filled slot and finds the slot with
// the highest age rank.
// ----------------------------------------------------------------------------
module flc_lookup (
  input  flc_pkg::blk_t     blk_i,
  input  flc_pkg::blk_arr_t blocks_i,
  input  flc_pkg::age_arr_t ages_i,
  input  flc_pkg::fill_t    filled_i,
  output flc_pkg::look_t    look_o
);
  import flc_pkg::*;

  always_comb begin
    logic found;
    slot_t hit_slot;
    slot_t best;
    age_t  best_age;
    found    = 1'b0;
    hit_slot = '0;
    best     = '0;
    best_age = ages_i[0];
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && (i < int'(filled_i)) && (blocks_i[i] == blk_i)) begin
        found    = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      // Ties keep the lowest slot.
      if ((i > 0) && (i < int'(filled_i)) && (ages_i[i] > best_age)) begin
        best     = SLOT_W'(i);
        best_age = ages_i[i];
      end
    end
    look_o.hit      = found;
    look_o.hit_slot = hit_slot;
    look_o.old_slot = best;
  end

endmodule

// File: src/flc_store.sv
// ----------------------------------------------------------------------------
// flc_store: slot block numbers, age ranks and fill count
// Applies one hit or miss update per cycle to the slot registers.
// ----------------------------------------------------------------------------
module flc_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  flc_pkg::upd_t     upd_i,
  output flc_pkg::blk_arr_t blocks_o,
  output flc_pkg::age_arr_t ages_o,
  output flc_pkg::fill_t    filled_o
);
  import flc_pkg::*;

  blk_arr_t blocks_q, blocks_d;
  age_arr_t ages_q, ages_d;
  fill_t    filled_q, filled_d;

  always_comb begin
    age_t lim;
    blocks_d = blocks_q;
    ages_d   = ages_q;
    filled_d = filled_q;
    lim      = ages_q[upd_i.slot];
    if (upd_i.en) begin
      if (upd_i.hit) begin
        if (upd_i.lru) begin
          // Slots younger than the hit slot age by one; the hit slot is newest.
          for (int i = 0; i < ENTRIES; i++) begin
            if (i < int'(filled_q)) begin
              if (SLOT_W'(i) == upd_i.slot) begin
                ages_d[i] = '0;
              end else if (ages_q[i] < lim) begin
                ages_d[i] = ages_q[i] + AGE_W'(1);
              end
            end
          end
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (i < int'(filled_q)) begin
            ages_d[i] = ages_q[i] + AGE_W'(1);
          end
        end
        ages_d[upd_i.slot]   = '0;
        blocks_d[upd_i.slot] = upd_i.blk;
        if (upd_i.grow) begin
          filled_d = filled_q + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blocks_q <= blocks_d;
    ages_q   <= ages_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else begin
      filled_q <= filled_d;
    end
  end

  assign blocks_o = blocks_q;
  assign ages_o   = ages_q;
  assign filled_o = filled_q;

endmodule

// File: src/fifo_lru_cache_replacement.sv
// ----------------------------------------------------------------------------
// fifo_lru_cache_replacement: fully associative block cache, FIFO or LRU
// Looks up one block number per cycle, fills or replaces a slot on a miss
// and reports hits, evictions and running counts.
// ----------------------------------------------------------------------------
// Usage
// A word (one block number on block_ref_i) is taken at a rising edge where
// start is high and busy is low. busy stays low, so a new word may be
// offered in every cycle. The word is registered, searched against all
// filled slots, and the result is registered: done_o rises at the rising
// edge after the accepting edge and stays high for exactly one cycle, with
// hit_o, slot_o, evicted_o and evicted_block_o valid in that cycle.
// hit_count_o and ref_count_o are the running counters; they include the
// word whose result is shown. Throughput is one word per cycle; the input
// register and the result register lie around the compare logic.
// The receiver cannot stall, so results are never held back.
// Configuration (index 0: policy_lru, index 1: slots_in_use) is written
// through cfg_we_i, cfg_idx_i and cfg_data_i while no word is in flight.
// Reset empties the cache, clears both counters and sets FIFO policy with
// all eight slots in use; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_lru_cache_replacement (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [flc_pkg::REF_W-1:0]            block_ref_i,
  input  logic                                 cfg_we_i,
  input  logic [flc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [flc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic                                 done_o,
  output logic                                 hit_o,
  output logic [flc_pkg::SLOT_OUT_W-1:0]       slot_o,
  output logic                                 evicted_o,
  output logic [flc_pkg::EVB_W-1:0]            evicted_block_o,
  output logic [flc_pkg::CNT_W-1:0]            hit_count_o,
  output logic [flc_pkg::CNT_W-1:0]            ref_count_o
);
  import flc_pkg::*;

  // The pipeline never holds a word back.
  assign busy = 1'b0;

  // Configuration registers.
  logic             policy_q;
  logic [SIU_W-1:0] siu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b0;
      siu_q    <= SIU_W'(8);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLICY: policy_q <= cfg_data_i[0];
        CFG_SIZE:   siu_q    <= SIU_W'(cfg_data_i);
        default:    ;
      endcase
    end
  end

  // Input register: one block number per cycle.
  logic in_valid_q;
  blk_t in_blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_blk_q <= BLOCK_BITS'(block_ref_i);
    end
  end

  // Slot state and the parallel search over it.
  blk_arr_t blocks;
  age_arr_t ages;
  fill_t    filled;
  look_t    look;
  upd_t     upd;

  flc_lookup u_lookup (
    .blk_i    (in_blk_q),
    .blocks_i (blocks),
    .ages_i   (ages),
    .filled_i (filled),
    .look_o   (look)
  );

  // Effective cache size: zero acts as one, anything above the built entry
  // count acts as the entry count. When the size is shrunk below the fill
  // count, the cache simply counts as full.
  fill_t size;
  logic  full;
  slot_t where;
  logic  evict;

  always_comb begin
    if (siu_q == '0) begin
      size = FILL_W'(1);
    end else if (int'(siu_q) > ENTRIES) begin
      size = FILL_W'(ENTRIES);
    end else begin
      size = FILL_W'(siu_q);
    end
    full  = (filled >= size);
    evict = !look.hit && full;
    if (look.hit) begin
      where = look.hit_slot;
    end else if (!full) begin
      where = SLOT_W'(filled);
    end else begin
      where = look.old_slot;
    end
    upd.en   = in_valid_q;
    upd.hit  = look.hit;
    upd.lru  = policy_q;
    upd.grow = !look.hit && !full;
    upd.slot = where;
    upd.blk  = in_blk_q;
  end

  flc_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .blocks_o (blocks),
    .ages_o   (ages),
    .filled_o (filled)
  );

  // Saturating hit and reference counters.
  logic [CNT_W-1:0] hits_q, refs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q <= '0;
      refs_q <= '0;
    end else if (in_valid_q) begin
      if (refs_q != '1) begin
        refs_q <= refs_q + CNT_W'(1);
      end
      if (look.hit && (hits_q != '1)) begin
        hits_q <= hits_q + CNT_W'(1);
      end
    end
  end

  // Result register.
  logic  done_q;
  logic  hit_q;
  slot_t slot_q;
  logic  evicted_q;
  blk_t  evb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      hit_q     <= look.hit;
      slot_q    <= where;
      evicted_q <= evict;
      evb_q     <= evict ? blocks[where] : '0;
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign slot_o          = SLOT_OUT_W'(slot_q);
  assign evicted_o       = evicted_q;
  assign evicted_block_o = EVB_W'(evb_q);
  assign hit_count_o     = hits_q;
  assign ref_count_o     = refs_q;

`ifndef ASSERT_OFF
  // An accepted word produces its result strobe after the input and result registers.
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result strobe missing two cycles after an accepted word");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && evicted_o))
    else $error("hit and eviction reported together");

  // The fill count never exceeds the built entry count.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(filled) <= ENTRIES)
    else $error("fill count above entry count");

  // Hits can never outnumber references.
  a_hits_le_refs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_count_o <= ref_count_o)
    else $error("hit count above reference count");
`endif

endmodule
